FILE: design/scs_pkg.sv
// Shared constants, types and helpers of the polynomial sine/cosine/tangent block.
`timescale 1ns / 1ps
package scs_pkg;

  localparam int ANG_W   = 24;   // Q8.16 angle
  localparam int KIND_W  = 2;
  localparam int ARG_W   = 41;   // signed Q32 angle argument
  localparam int MAG_W   = 40;   // argument magnitude
  localparam int HP_W    = 32;   // Horner accumulator, Q28
  localparam int X_W     = 30;   // reduced angle, Q28
  localparam int VAL_W   = 32;   // Q16.16 result
  localparam int NUM_W   = 48;   // tangent dividend
  localparam int DEN_W   = 32;   // tangent divisor
  localparam int PROD_W  = HP_W + X_W;
  localparam int FRAC    = 28;

  localparam int RED_STEPS  = 7;   // half-turn count stays below 2^7
  localparam int HORN_STEPS = 6;
  localparam int DIV_STEPS  = VAL_W;

  localparam logic [KIND_W-1:0] KIND_SIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAN = 2'd2;

  localparam logic [63:0]              PI_Q32      = 64'd13493037705;
  localparam logic signed [ARG_W-1:0]  HALF_PI_Q32 = 41'sd6746518852;

  localparam logic signed [HP_W-1:0] C1 = 32'sd268443509;
  localparam logic signed [HP_W-1:0] C2 = 32'sd83824;
  localparam logic signed [HP_W-1:0] C3 = 32'sd44436000;
  localparam logic signed [HP_W-1:0] C4 = 32'sd547439;
  localparam logic signed [HP_W-1:0] C5 = 32'sd2761127;
  localparam logic signed [HP_W-1:0] C6 = 32'sd258152;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  // Term added after the multiply of Horner step idx.
  function automatic logic signed [HP_W-1:0] horner_add(input int idx);
    logic signed [HP_W-1:0] r;
    case (idx)
      0:       r = C5;
      1:       r = -C4;
      2:       r = -C3;
      3:       r = -C2;
      4:       r = C1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Lane 0 carries the sine argument, lane 1 the cosine argument.
  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [1:0]                 neg;
    logic [1:0]                 parity;
    logic [1:0][MAG_W-1:0]      rem;
    logic [1:0][HP_W-1:0]       h;
    logic [VAL_W-1:0]           trig;
    logic                       s_neg;
    logic                       c_neg;
    logic                       c_zero;
    logic                       ovf;
    logic [NUM_W-1:0]           num;
    logic [DEN_W-1:0]           den;
    logic [VAL_W-1:0]           quo;
  } scs_stage_t;

endpackage

FILE: design/scs_in_if.sv
// Input channel: angle and function kind.
`timescale 1ns / 1ps
interface scs_in_if import scs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ANG_W-1:0]  angle;
  logic [KIND_W-1:0]        kind;
  modport source (output valid, angle, kind, input ready);
  modport sink   (input valid, angle, kind, output ready);
endinterface

FILE: design/scs_out_if.sv
// Output channel: result value and saturation flag.
`timescale 1ns / 1ps
interface scs_out_if import scs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  value;
  logic                     saturated;
  modport source (output valid, value, saturated, input ready);
  modport sink   (input valid, value, saturated, output ready);
endinterface

FILE: design/scs_reduce_cell.sv
// Reduction cell: one compare-subtract of pi shifted by K on both lanes.
`timescale 1ns / 1ps
module scs_reduce_cell import scs_pkg::*; #(
  parameter int K = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  scs_stage_t in_st,
  output logic       out_valid,
  output scs_stage_t out_st
);
  localparam logic [63:0]      PI_WIDE = PI_Q32 << K;
  localparam logic [MAG_W-1:0] PI_SH   = PI_WIDE[MAG_W-1:0];

  scs_stage_t st_next;

  always_comb begin
    st_next = in_st;
    for (int l = 0; l < 2; l++) begin
      if (in_st.rem[l] >= PI_SH) begin
        st_next.rem[l] = in_st.rem[l] - PI_SH;
        if (K == 0) st_next.parity[l] = 1'b1;
      end else begin
        if (K == 0) st_next.parity[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_st <= st_next;
  end
endmodule

FILE: design/scs_horner_cell.sv
// Horner cell: h = add + round(h * x) on both lanes.
`timescale 1ns / 1ps
module scs_horner_cell import scs_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  scs_stage_t in_st,
  output logic       out_valid,
  output scs_stage_t out_st
);
  localparam logic signed [HP_W-1:0] ADD = horner_add(IDX);

  scs_stage_t st_next;
  logic [1:0][HP_W-1:0]   hm;
  logic [1:0][X_W-1:0]    x;
  logic [1:0][PROD_W-1:0] prod;
  logic [1:0][PROD_W-1:0] rnd;
  logic signed [1:0][HP_W-1:0] term;

  always_comb begin
    st_next = in_st;
    for (int l = 0; l < 2; l++) begin
      x[l]    = in_st.rem[l][X_W+3:4];
      hm[l]   = in_st.h[l][HP_W-1] ? HP_W'(-$signed(in_st.h[l])) : in_st.h[l];
      prod[l] = PROD_W'(hm[l]) * PROD_W'(x[l]);
      rnd[l]  = (prod[l] + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
      term[l] = in_st.h[l][HP_W-1] ? -$signed(rnd[l][HP_W-1:0])
                                   : $signed(rnd[l][HP_W-1:0]);
      st_next.h[l] = term[l] + ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_st <= st_next;
  end
endmodule

FILE: design/scs_prep_cell.sv
// Sign fix-up, Q16 rounding and tangent dividend/divisor setup.
`timescale 1ns / 1ps
module scs_prep_cell import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  scs_stage_t in_st,
  output logic       out_valid,
  output scs_stage_t out_st
);
  scs_stage_t st_next;
  logic signed [HP_W-1:0] s, c, sel;
  logic [HP_W-1:0]        smag, cmag, selmag, r16;

  always_comb begin
    st_next = in_st;
    s = (in_st.neg[0] ^ in_st.parity[0]) ? -$signed(in_st.h[0]) : $signed(in_st.h[0]);
    c = (in_st.neg[1] ^ in_st.parity[1]) ? -$signed(in_st.h[1]) : $signed(in_st.h[1]);
    smag = s[HP_W-1] ? HP_W'(-s) : HP_W'(s);
    cmag = c[HP_W-1] ? HP_W'(-c) : HP_W'(c);
    sel    = (in_st.kind == KIND_COS) ? c : s;
    selmag = (in_st.kind == KIND_COS) ? cmag : smag;
    r16 = (selmag + HP_W'(2048)) >> 12;
    st_next.trig   = sel[HP_W-1] ? VAL_W'(-$signed(r16)) : VAL_W'(r16);
    st_next.s_neg  = s[HP_W-1];
    st_next.c_neg  = c[HP_W-1];
    st_next.c_zero = (c == '0);
    st_next.num    = NUM_W'(smag) << 16;
    st_next.den    = DEN_W'(cmag);
    st_next.ovf    = {16'b0, st_next.num} >= {st_next.den, 32'b0};
    st_next.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_st <= st_next;
  end
endmodule

FILE: design/scs_div_cell.sv
// Restoring divider cell: settle quotient bit BIT.
`timescale 1ns / 1ps
module scs_div_cell import scs_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  scs_stage_t in_st,
  output logic       out_valid,
  output scs_stage_t out_st
);
  scs_stage_t st_next;
  logic [63:0] dsh;

  always_comb begin
    st_next = in_st;
    dsh = 64'(in_st.den) << BIT;
    if (64'(in_st.num) >= dsh) begin
      st_next.num      = in_st.num - dsh[NUM_W-1:0];
      st_next.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) out_st <= st_next;
  end
endmodule

FILE: design/poly_sine_cosine_tangent_top.sv
// Top level: pipelined fixed-point sine, cosine and tangent.
`timescale 1ns / 1ps
// Takes a Q8.16 radian angle and a kind (sine, cosine, tangent) and returns
// a Q16.16 result. One transfer is accepted every cycle unless a result
// waits at the output. The row of cells is made up of:
// an input register, 7 reduction cells (one compare-subtract of a multiple
// of pi each, sine and cosine lanes side by side), 6 Horner cells (one
// multiply per lane each), a fix-up cell, 32 divider cells (one quotient bit
// each, for the tangent) and the output register, 48 registers in all with
// the first loaded at the input transfer. All cells advance together
// whenever the output register is empty or its result is being taken; while
// a result waits, the whole row holds, empty slots included, and the input
// stalls with it. Tangent saturates to the 32-bit range and raises
// saturated; a zero cosine also raises it. Kind 3 returns zero.
module poly_sine_cosine_tangent_top import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  scs_in_if.sink     in_ch,
  scs_out_if.source  out_ch
);
  localparam int RED0  = 0;
  localparam int HORN0 = RED0 + RED_STEPS;
  localparam int PREP  = HORN0 + HORN_STEPS;
  localparam int DIV0  = PREP + 1;
  localparam int NCELL = DIV0 + DIV_STEPS;

  scs_stage_t st [0:NCELL];
  logic       vld [0:NCELL];
  logic       en;

  scs_stage_t             st0_next;
  logic signed [ARG_W-1:0] a_sin, a_cos;

  // Advance the whole row when the output register can take a result.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Build both lane arguments from the angle.
  always_comb begin
    st0_next = '0;
    a_sin = $signed({in_ch.angle[ANG_W-1], in_ch.angle, 16'b0});
    a_cos = HALF_PI_Q32 - a_sin;
    st0_next.kind   = in_ch.kind;
    st0_next.neg    = {a_cos[ARG_W-1], a_sin[ARG_W-1]};
    st0_next.rem[0] = a_sin[ARG_W-1] ? MAG_W'(-a_sin) : MAG_W'(a_sin);
    st0_next.rem[1] = a_cos[ARG_W-1] ? MAG_W'(-a_cos) : MAG_W'(a_cos);
    st0_next.h[0]   = -C6;
    st0_next.h[1]   = -C6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_ch.valid;
    end
    if (en) st[0] <= st0_next;
  end

  genvar i;
  generate
    for (i = 0; i < RED_STEPS; i++) begin : g_red
      scs_reduce_cell #(.K(RED_STEPS - 1 - i)) u_cell (
        .clk, .rst, .en,
        .in_valid (vld[RED0 + i]), .in_st (st[RED0 + i]),
        .out_valid(vld[RED0 + i + 1]), .out_st(st[RED0 + i + 1])
      );
    end
    for (i = 0; i < HORN_STEPS; i++) begin : g_horn
      scs_horner_cell #(.IDX(i)) u_cell (
        .clk, .rst, .en,
        .in_valid (vld[HORN0 + i]), .in_st (st[HORN0 + i]),
        .out_valid(vld[HORN0 + i + 1]), .out_st(st[HORN0 + i + 1])
      );
    end
    for (i = 0; i < DIV_STEPS; i++) begin : g_div
      scs_div_cell #(.BIT(DIV_STEPS - 1 - i)) u_cell (
        .clk, .rst, .en,
        .in_valid (vld[DIV0 + i]), .in_st (st[DIV0 + i]),
        .out_valid(vld[DIV0 + i + 1]), .out_st(st[DIV0 + i + 1])
      );
    end
  endgenerate

  scs_prep_cell u_prep (
    .clk, .rst, .en,
    .in_valid (vld[PREP]), .in_st (st[PREP]),
    .out_valid(vld[DIV0]), .out_st(st[DIV0])
  );

  // Pick the final value and apply tangent clamping.
  scs_stage_t              fin;
  logic signed [VAL_W-1:0] value_next;
  logic                    sat_next;
  logic                    tneg;

  always_comb begin
    fin        = st[NCELL];
    tneg       = fin.s_neg ^ fin.c_neg;
    value_next = '0;
    sat_next   = 1'b0;
    case (fin.kind)
      KIND_SIN, KIND_COS: begin
        value_next = $signed(fin.trig);
      end
      KIND_TAN: begin
        if (fin.c_zero) begin
          sat_next   = 1'b1;
          value_next = fin.s_neg ? VAL_MIN : VAL_MAX;
        end else if (fin.ovf) begin
          sat_next   = 1'b1;
          value_next = tneg ? VAL_MIN : VAL_MAX;
        end else if (tneg) begin
          if (fin.quo > VAL_W'(VAL_MIN)) begin
            sat_next   = 1'b1;
            value_next = VAL_MIN;
          end else begin
            value_next = -$signed(fin.quo);
          end
        end else begin
          if (fin.quo[VAL_W-1]) begin
            sat_next   = 1'b1;
            value_next = VAL_MAX;
          end else begin
            value_next = $signed(fin.quo);
          end
        end
      end
      default: begin
        value_next = '0;
        sat_next   = 1'b0;
      end
    endcase
  end

  // Output register: hold the result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vld[NCELL];
    end
    if (en) begin
      out_ch.value     <= value_next;
      out_ch.saturated <= sat_next;
    end
  end
endmodule

FILE: sim/tb_poly_sine_cosine_tangent_top.sv
// Testbench for the pipelined sine, cosine and tangent block: predicted results checked in order.
`timescale 1ns / 1ps
module tb_poly_sine_cosine_tangent_top;
  import scs_pkg::*;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic [KIND_W-1:0]       kind;
  } angle_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    saturated;
  } trig_res_t;

  localparam longint PI_FIX   = 64'd13493037705;
  localparam longint HPI_FIX  = 64'sd6746518852;
  localparam int     N_RANDOM = 1330;
  localparam int     LATENCY  = 48;

  logic clk;
  logic rst;

  scs_in_if  in_ch ();
  scs_out_if out_ch ();

  poly_sine_cosine_tangent_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  angle_req_t pending_q[$];
  trig_res_t  expected_q[$];
  int         mismatch_cnt;
  bit         stim_done;
  bit         calm;          // last part of the run: no idling on either side
  int         src_idle;
  int         snk_idle;

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Magnitude product, Q28 rounding half away from zero, sign restored.
  function automatic longint fix_mul(input longint a, input longint b);
    longint m;
    m = (abs64(a) * abs64(b) + (64'sd1 <<< 27)) >>> 28;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Sine of a Q32 angle, Q28 result.
  function automatic longint sine_fix(input longint arg);
    longint a, n, x, h;
    a = abs64(arg);
    n = a / PI_FIX;
    x = (a - n * PI_FIX) >>> 4;
    h = -64'sd258152;
    h = 64'sd2761127 + fix_mul(h, x);
    h = -64'sd547439 + fix_mul(h, x);
    h = -64'sd44436000 + fix_mul(h, x);
    h = -64'sd83824 + fix_mul(h, x);
    h = 64'sd268443509 + fix_mul(h, x);
    h = fix_mul(h, x);
    if ((arg < 0) != n[0]) h = -h;
    return h;
  endfunction

  function automatic longint to_q16(input longint v);
    longint m;
    m = (abs64(v) + 64'sd2048) >>> 12;
    return (v < 0) ? -m : m;
  endfunction

  function automatic trig_res_t predict_trig(input angle_req_t req);
    trig_res_t r;
    longint    a32, s, c, m;
    a32 = longint'(req.angle) * 65536;
    r.value = '0;
    r.saturated = 1'b0;
    case (req.kind)
      KIND_SIN: r.value = VAL_W'(to_q16(sine_fix(a32)));
      KIND_COS: r.value = VAL_W'(to_q16(sine_fix(HPI_FIX - a32)));
      KIND_TAN: begin
        s = sine_fix(a32);
        c = sine_fix(HPI_FIX - a32);
        if (c == 0) begin
          r.saturated = 1'b1;
          r.value = (s < 0) ? VAL_MIN : VAL_MAX;
        end else begin
          m = (abs64(s) <<< 16) / abs64(c);
          if ((s < 0) != (c < 0)) begin
            if (m > 64'sd2147483648) begin
              m = 64'sd2147483648;
              r.saturated = 1'b1;
            end
            r.value = VAL_W'(-m);
          end else begin
            if (m > 64'sd2147483647) begin
              m = 64'sd2147483647;
              r.saturated = 1'b1;
            end
            r.value = VAL_W'(m);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_angle(input int ang, input int kind);
    angle_req_t req;
    req.angle = ANG_W'(ang);
    req.kind = KIND_W'(kind);
    pending_q.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: present the head of the pending queue, idle in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_idle <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // Previous transfer done (or none in flight): pick the next one.
      if (in_ch.valid) pending_q.pop_front();
      if (src_idle > 0) begin
        src_idle <= src_idle - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        src_idle <= $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.angle <= pending_q[0].angle;
        in_ch.kind  <= pending_q[0].kind;
        expected_q.push_back(predict_trig(pending_q[0]));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: stall in random bursts, check every result transfer.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_idle <= 0;
      mismatch_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected result: value=%0d saturated=%0b",
                     out_ch.value, out_ch.saturated);
        end else begin
          if (out_ch.value !== expected_q[0].value ||
              out_ch.saturated !== expected_q[0].saturated) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                       expected_q[0].value, expected_q[0].saturated,
                       out_ch.value, out_ch.saturated);
          end
          expected_q.pop_front();
        end
      end
      if (snk_idle > 0) begin
        snk_idle <= snk_idle - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        snk_idle <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners, then random angles, then drain and judge.
  initial begin
    int sel, ang;
    rst = 1'b1;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.angle = '0;
    in_ch.kind = KIND_SIN;
    out_ch.ready = 1'b0;
    // Field extremes with every kind, including the unused kind.
    for (int k = 0; k < 4; k++) begin
      queue_angle(-8388608, k);
      queue_angle(8388607, k);
      queue_angle(0, k);
    end
    // Near pi/2: cosine close to zero, tangent overflow on both sides.
    queue_angle(102944, KIND_TAN);
    queue_angle(102943, KIND_TAN);
    queue_angle(-102944, KIND_TAN);
    queue_angle(308831, KIND_TAN);
    // Half-turn boundaries flip the sign through parity.
    queue_angle(205887, KIND_SIN);
    queue_angle(205888, KIND_SIN);
    queue_angle(-205888, KIND_SIN);
    queue_angle(411775, KIND_COS);
    queue_angle(-1, KIND_TAN);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) ang = $urandom_range(0, 32'hFFFFFF);
      else if (sel < 8) ang = int'($urandom_range(0, 411774)) - 205887;
      else ang = 102944 + 205887 * int'($urandom_range(0, 80)) - 40 * 205887
                 + int'($urandom_range(0, 8)) - 4;
      // Kind 3 kept rare; it only returns zero.
      queue_angle(ang, ($urandom_range(0, 30) == 0) ? 3 : $urandom_range(0, 2));
      if (i == N_RANDOM - 200) begin
        while (pending_q.size() > 200) @(posedge clk);
      end
    end
    while (pending_q.size() > 250) @(posedge clk);
    calm <= 1'b1;
    while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
